[hw/rtl/etas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etas_pkg
// Shared field widths and item codes for the encoder table angle search.
// ----------------------------------------------------------------------------
package etas_pkg;

  // Item kind carried in tuser on the input stream
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Fixed field widths of the stream payloads
  localparam int unsigned INDEX_W    = 9;
  localparam int unsigned FIELD_W    = 12;
  localparam int unsigned ANGLE_BITS = 12;
  localparam int unsigned COST_W     = 25;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned TURN_W     = POS_W - ANGLE_BITS;

  // Half a turn in angle codes
  localparam int HALF_TURN = 2 ** (ANGLE_BITS - 1);

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 80;

endpackage

[hw/rtl/encoder_table_angle_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_table_angle_search
// Optical encoder angle lookup: calibration table search and turn counting.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries two kinds of transfer, told apart by tuser.
//   A load transfer writes one calibration entry (ref_a, ref_b) at
//   entry_index; an index at or beyond TABLE_DEPTH is dropped. It gives no
//   result and leaves the input ready. A sample transfer searches the table
//   for the entry closest to (sample_a, sample_b) and gives one result
//   transfer on the master stream: angle, multi-turn position, chosen index
//   and cost. Only entries already loaded may be reached by a search.
// Search sequence:
//   A sample runs its table probes in turn: two initial probes plus one or
//   two per refinement step (10 to 18 probes at a depth of 512). Each
//   probe is one read of the calibration memory, then the squares and the
//   compare; the probes are strictly dependent. The index-to-angle scaling
//   and the result register load follow, and the input takes the next
//   transfer once the result register is loaded.
// Reset and stall:
//   Reset clears the turn counter, the last angle and the result valid; the
//   table contents stay undefined until loaded. A finished result sits in
//   the output register; the next transfer is taken while it waits, and a
//   later result holds in the search engine until the register drains.
// ----------------------------------------------------------------------------
module encoder_table_angle_search #(
  parameter int unsigned TABLE_DEPTH = 512,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: entry_index[8:0], ref_a[20:9], ref_b[32:21], sample_a[44:33],
  //        sample_b[56:45], zero fill [63:57]
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [etas_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: kind[0] (0 load table entry, 1 sample)
  input  logic                             s_axis_tuser,
  // tdata: angle_code[11:0], position[43:12], best_index[52:44],
  //        best_cost[77:53], zero fill [79:78]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [etas_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import etas_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned SQ_W  = 2 * SB;
  localparam int unsigned CW    = SQ_W + 1;
  localparam logic [IDX_W:0]   DEPTH_C  = (IDX_W + 1)'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] STEP0    = IDX_W'(TABLE_DEPTH / 2 + 1);
  localparam logic [IDX_W-1:0] STEP_ONE = IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_FWD,
    PH_BWD
  } phase_e;

  // Input fields
  logic [INDEX_W-1:0] in_entry_index;
  logic [FIELD_W-1:0] in_ref_a, in_ref_b, in_sample_a, in_sample_b;

  assign in_entry_index = s_axis_tdata[8:0];
  assign in_ref_a       = s_axis_tdata[20:9];
  assign in_ref_b       = s_axis_tdata[32:21];
  assign in_sample_a    = s_axis_tdata[44:33];
  assign in_sample_b    = s_axis_tdata[56:45];

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [SB-1:0]       sa_q, sb_q;
  logic [IDX_W-1:0]    cand_q, cand_d;
  logic [IDX_W-1:0]    best_q, best_d;
  logic [CW-1:0]       best_cost_q, best_cost_d;
  logic [IDX_W-1:0]    step_q, step_d;
  logic                dir_q, dir_d;       // 1: step up, 0: step down
  logic [SQ_W-1:0]     sq_a_q, sq_b_q;
  logic [ANGLE_BITS-1:0] angle_q;
  logic [ANGLE_BITS-1:0] last_angle_q;
  logic [TURN_W-1:0]   turns_q;            // turn offset in whole turns
  logic                m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic                s_xfer;
  logic                load_we;
  logic                rd_en;
  logic [2*SB-1:0]     rd_data;
  logic [SB-1:0]       ta, tb, da, db;
  logic [CW-1:0]       cost_c;
  logic                better;
  logic                div_start;
  logic                div_done;
  logic [ANGLE_BITS-1:0] div_angle;
  logic                out_free;

  // Turn tracking on the result cycle
  logic signed [ANGLE_BITS:0] angle_diff;
  logic [TURN_W-1:0]   turns_d;

  function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] base,
                                               input logic [IDX_W-1:0] s);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, s};
    if (sum >= DEPTH_C) begin
      sum = sum - DEPTH_C;
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] s);
    logic [IDX_W:0] dif;
    dif = {1'b0, base} - {1'b0, s};
    if (dif[IDX_W]) begin
      dif = dif + DEPTH_C;
    end
    return dif[IDX_W-1:0];
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign load_we       = s_xfer && (s_axis_tuser == KIND_LOAD) &&
                         (32'(in_entry_index) < TABLE_DEPTH);

  etas_cal_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (2 * SB)
  ) u_cal_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (IDX_W'(in_entry_index)),
    .wdata_i ({SB'(in_ref_b), SB'(in_ref_a)}),
    .re_i    (rd_en),
    .raddr_i (cand_d),
    .rdata_o (rd_data)
  );

  // Distance terms of the entry just read
  assign ta = rd_data[SB-1:0];
  assign tb = rd_data[2*SB-1:SB];
  assign da = (ta > sa_q) ? (ta - sa_q) : (sa_q - ta);
  assign db = (tb > sb_q) ? (tb - sb_q) : (sb_q - tb);

  assign cost_c = {1'b0, sq_a_q} + {1'b0, sq_b_q};
  assign better = (phase_q == PH_FIRST) || (cost_c < best_cost_q);

  etas_scale #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .index_i (best_d),
    .done_o  (div_done),
    .angle_o (div_angle)
  );

  // Search sequencer: one probe per read/square/compare round
  always_comb begin
    logic [IDX_W-1:0] nb;
    logic             ndir;
    logic             head;
    logic [IDX_W-1:0] step_n;

    state_d     = state_q;
    phase_d     = phase_q;
    cand_d      = cand_q;
    best_d      = best_q;
    best_cost_d = best_cost_q;
    step_d      = step_q;
    dir_d       = dir_q;
    rd_en       = 1'b0;
    div_start   = 1'b0;
    nb          = better ? cand_q : best_q;
    ndir        = dir_q;
    head        = 1'b0;
    step_n      = step_q >> 1;
    if (step_n == '0) begin
      step_n = STEP_ONE;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_xfer && (s_axis_tuser == KIND_SAMPLE)) begin
          cand_d  = '0;
          phase_d = PH_FIRST;
          step_d  = STEP0;
          dir_d   = 1'b1;
          rd_en   = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        best_d      = nb;
        best_cost_d = better ? cost_c : best_cost_q;
        case (phase_q)
          PH_FIRST: begin
            cand_d  = STEP0;
            phase_d = PH_SECOND;
            rd_en   = 1'b1;
            state_d = ST_READ;
          end
          PH_FWD: begin
            if (better) begin
              ndir = !dir_q;
              head = 1'b1;
            end else begin
              cand_d  = dir_q ? wrap_down(best_q, step_q) : wrap_up(best_q, step_q);
              phase_d = PH_BWD;
              rd_en   = 1'b1;
              state_d = ST_READ;
            end
          end
          default: begin
            head = 1'b1;
          end
        endcase
        if (head) begin
          dir_d = ndir;
          if (step_q == STEP_ONE) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            step_d  = step_n;
            cand_d  = ndir ? wrap_up(nb, step_n) : wrap_down(nb, step_n);
            phase_d = PH_FWD;
            rd_en   = 1'b1;
            state_d = ST_READ;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_free = !m_valid_q || m_axis_tready;

  // A jump of more than half a turn moves the turn count
  assign angle_diff = $signed({1'b0, angle_q}) - $signed({1'b0, last_angle_q});
  always_comb begin
    turns_d = turns_q;
    if (angle_diff > (ANGLE_BITS + 1)'(HALF_TURN)) begin
      turns_d = turns_q - TURN_W'(1);
    end else if (angle_diff < -(ANGLE_BITS + 1)'(HALF_TURN)) begin
      turns_d = turns_q + TURN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_FIRST;
      m_valid_q    <= 1'b0;
      last_angle_q <= '0;
      turns_q      <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (state_q == ST_OUT && out_free) begin
        m_valid_q    <= 1'b1;
        last_angle_q <= angle_q;
        turns_q      <= turns_d;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Search payload
  always_ff @(posedge clk_i) begin
    cand_q      <= cand_d;
    best_q      <= best_d;
    best_cost_q <= best_cost_d;
    step_q      <= step_d;
    dir_q       <= dir_d;
    if (s_xfer) begin
      sa_q <= SB'(in_sample_a);
      sb_q <= SB'(in_sample_b);
    end
    if (state_q == ST_READ) begin
      sq_a_q <= SQ_W'(da) * SQ_W'(da);
      sq_b_q <= SQ_W'(db) * SQ_W'(db);
    end
    if (state_q == ST_DIV && div_done) begin
      angle_q <= div_angle;
    end
    // Position is the turn count above the angle bits
    if (state_q == ST_OUT && out_free) begin
      m_data_q <= {2'b00, COST_W'(best_cost_q), INDEX_W'(best_q), turns_d, angle_q,
                   angle_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[hw/rtl/etas_cal_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etas_cal_ram
// Calibration table memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module etas_cal_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/etas_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etas_scale
// Index to angle scaling: floor(index * 2^ANGLE_BITS / TABLE_DEPTH) by
// multiplication with a rounded-up reciprocal, with a registered result.
// ----------------------------------------------------------------------------
module etas_scale #(
  parameter int unsigned TABLE_DEPTH = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] index_i,
  output logic                           done_o,
  output logic [etas_pkg::ANGLE_BITS-1:0] angle_o
);
  import etas_pkg::*;

  // A reciprocal scaled by 2^(ANGLE_BITS + 2*IDX_W) keeps the total error
  // below 1/TABLE_DEPTH for every index, so the floor is exact.
  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned SHIFT   = 2 * IDX_W;
  localparam int unsigned RECIP_W = ANGLE_BITS + IDX_W + 1;
  localparam int unsigned PROD_W  = IDX_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << (ANGLE_BITS + SHIFT)) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  logic                  done_q;
  logic [ANGLE_BITS-1:0] angle_q;
  logic [PROD_W-1:0]     prod;

  assign prod = PROD_W'(index_i) * PROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      angle_q <= prod[SHIFT +: ANGLE_BITS];
    end
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

endmodule

[hw/rtl/etas_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etas_checker
// Port-level checks for the encoder table angle search, bound to the top.
// ----------------------------------------------------------------------------
module etas_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [etas_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import etas_pkg::*;

  logic s_xfer;
  assign s_xfer = s_axis_tvalid && s_axis_tready;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A load leaves the input ready for the next transfer
  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser == KIND_LOAD) |=> s_axis_tready)
    else $error("load transfer did not free the input");

  // A sample keeps the input busy while the search runs
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser == KIND_SAMPLE) |=> !s_axis_tready)
    else $error("input taken during search");

  // Turn offset is whole turns: low position bits equal the angle
  a_pos_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:12] == m_axis_tdata[11:0])
    else $error("position does not match angle");

endmodule

bind encoder_table_angle_search etas_checker u_etas_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the encoder table angle search.
// ----------------------------------------------------------------------------
// Loads the whole calibration table with a diamond-shaped reference curve so
// that no search can reach an unloaded entry. A short directed table then
// runs. After it come random transfers, mostly shaft rotations and jumps near
// real table points. Every accepted sample runs through a bit-exact model of
// the search and the turn counter here, and each result transfer is checked
// field by field against the oldest expected result. The random part runs in
// three phases of stream idling, the last with neither stream idling.
// ----------------------------------------------------------------------------
module tb_top;
  import etas_pkg::*;

  localparam int unsigned DEPTH        = 512;
  localparam int unsigned FULL_TURN    = 4096;
  localparam int unsigned PHASE_ITEMS  = 75;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 64;

  typedef struct packed {
    logic                  kind;
    logic [INDEX_W-1:0]    index;
    logic [FIELD_W-1:0]    ref_a;
    logic [FIELD_W-1:0]    ref_b;
    logic [FIELD_W-1:0]    smp_a;
    logic [FIELD_W-1:0]    smp_b;
  } item_t;

  // Last member in the lowest bits, as on the result stream
  typedef struct packed {
    logic [COST_W-1:0]     cost;
    logic [INDEX_W-1:0]    index;
    logic [POS_W-1:0]      position;
    logic [ANGLE_BITS-1:0] angle;
  } result_t;

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Local copy of the block state
  logic [FIELD_W-1:0]    cal_a [DEPTH];
  logic [FIELD_W-1:0]    cal_b [DEPTH];
  logic [ANGLE_BITS-1:0] track_angle;
  logic [POS_W-1:0]      turn_count;

  result_t               pending_results [$];
  row_t                  directed [$];
  int unsigned           mismatches = 0;
  int unsigned           src_idle;
  int unsigned           sink_idle;
  int unsigned           quiet_cycles = 0;

  encoder_table_angle_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Reference curve: two triangle waves a quarter turn apart
  function automatic logic [FIELD_W-1:0] tri_wave(int unsigned k);
    int unsigned m;
    m = k % DEPTH;
    return (m < DEPTH / 2) ? FIELD_W'(m * 16) : FIELD_W'((DEPTH - 1 - m) * 16);
  endfunction

  function automatic logic [FIELD_W-1:0] curve_a(int unsigned k);
    return tri_wave(k);
  endfunction

  function automatic logic [FIELD_W-1:0] curve_b(int unsigned k);
    return tri_wave(k + DEPTH / 4);
  endfunction

  function automatic item_t load_item(int unsigned idx, logic [FIELD_W-1:0] a,
                                      logic [FIELD_W-1:0] b,
                                      logic [FIELD_W-1:0] junk_a,
                                      logic [FIELD_W-1:0] junk_b);
    item_t it;
    it.kind  = KIND_LOAD;
    it.index = INDEX_W'(idx);
    it.ref_a = a;
    it.ref_b = b;
    it.smp_a = junk_a;
    it.smp_b = junk_b;
    return it;
  endfunction

  function automatic item_t sample_item(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                                        logic [INDEX_W-1:0] junk_idx,
                                        logic [FIELD_W-1:0] junk_a,
                                        logic [FIELD_W-1:0] junk_b);
    item_t it;
    it.kind  = KIND_SAMPLE;
    it.index = junk_idx;
    it.ref_a = junk_a;
    it.ref_b = junk_b;
    it.smp_a = a;
    it.smp_b = b;
    return it;
  endfunction

  // Nudge a reading by a little sensor noise, clamped to the converter range
  function automatic logic [FIELD_W-1:0] jitter(logic [FIELD_W-1:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 40)) - 20;
    if (t < 0) t = 0;
    if (t > 4095) t = 4095;
    return FIELD_W'(t);
  endfunction

  function automatic logic [COST_W-1:0] probe_cost(int unsigned k, logic [FIELD_W-1:0] sa,
                                                   logic [FIELD_W-1:0] sb);
    int unsigned ta, tb, da, db;
    ta = cal_a[k % DEPTH];
    tb = cal_b[k % DEPTH];
    da = (ta > sa) ? ta - sa : sa - ta;
    db = (tb > sb) ? tb - sb : sb - tb;
    return COST_W'(da * da + db * db);
  endfunction

  function automatic int unsigned wrap_index(int unsigned base, int unsigned step, int dir);
    return (dir > 0) ? (base + step) % DEPTH : (base + DEPTH - step) % DEPTH;
  endfunction

  // Search the table, advance the turn counter, and return the result
  function automatic result_t locate_angle(logic [FIELD_W-1:0] sa, logic [FIELD_W-1:0] sb);
    int unsigned       best, step, cand, scaled;
    logic [COST_W-1:0] best_cost, c;
    int                dir, diff;
    logic [ANGLE_BITS-1:0] ang;
    result_t           r;
    best      = 0;
    best_cost = probe_cost(0, sa, sb);
    step      = DEPTH / 2 + 1;
    if (step < DEPTH) begin
      c = probe_cost(step, sa, sb);
      if (c < best_cost) begin
        best      = step;
        best_cost = c;
      end
    end
    dir = 1;
    while (step != 1) begin
      step = step / 2;
      if (step == 0) step = 1;
      cand = wrap_index(best, step, dir);
      c    = probe_cost(cand, sa, sb);
      if (c < best_cost) begin
        best      = cand;
        best_cost = c;
        dir       = -dir;
      end else begin
        cand = wrap_index(best, step, -dir);
        c    = probe_cost(cand, sa, sb);
        if (c < best_cost) begin
          best      = cand;
          best_cost = c;
        end
      end
    end
    scaled = best * FULL_TURN / DEPTH;
    ang    = scaled[ANGLE_BITS-1:0];
    diff   = int'(ang) - int'(track_angle);
    if (diff > HALF_TURN) turn_count = turn_count - FULL_TURN;
    else if (diff < -HALF_TURN) turn_count = turn_count + FULL_TURN;
    track_angle = ang;
    r.angle    = ang;
    r.position = POS_W'(ang) + turn_count;
    r.index    = best[INDEX_W-1:0];
    r.cost     = best_cost;
    return r;
  endfunction

  function automatic void add_row(item_t stim, bit typed, result_t want);
    row_t r;
    r.stim  = stim;
    r.typed = typed;
    r.want  = want;
    directed.push_back(r);
  endfunction

  // Drive one transfer on the slave stream, starting at a falling edge.
  // Update the local state at the accepting edge, and return at the next
  // falling edge with tvalid still high.
  task automatic transfer_item(item_t it, bit typed, result_t want);
    result_t predicted;
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {7'b0, it.smp_b, it.smp_a, it.ref_b, it.ref_a, it.index};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (it.kind == KIND_LOAD) begin
      // The index field cannot exceed the depth, so every load lands
      cal_a[it.index] = it.ref_a;
      cal_b[it.index] = it.ref_b;
    end else begin
      predicted = locate_angle(it.smp_a, it.smp_b);
      pending_results.push_back(typed ? want : predicted);
    end
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Receiver: drop tready at random, with odds of sink_idle in a hundred
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle);
  end

  // Compare every result transfer with the oldest expected result
  always @(posedge clk_i) begin
    result_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[ANGLE_BITS+POS_W+INDEX_W+COST_W-1:0];
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
      end else begin
        want = pending_results.pop_front();
        check_field("angle_code", want.angle, got.angle);
        check_field("position", want.position, got.position);
        check_field("best_index", want.index, got.index);
        check_field("best_cost", want.cost, got.cost);
      end
    end
  end

  // Watchdog: end the run once nothing has moved for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** encoder_table_angle_search: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    result_t     none;
    result_t     zero_hit;
    item_t       it;
    int unsigned walk_pos;
    int unsigned pick;
    int unsigned k;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_LOAD;
    m_axis_tready = 1'b0;
    track_angle   = '0;
    turn_count    = '0;
    src_idle      = 13;
    sink_idle     = 80;
    none          = '0;
    zero_hit      = '0;
    walk_pos      = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Load every entry before the first search, so no probe hits an
    // unloaded entry
    for (int unsigned i = 0; i < DEPTH; i++) begin
      transfer_item(load_item(i, curve_a(i), curve_b(i), FIELD_W'($urandom),
                              FIELD_W'($urandom)), 1'b0, none);
    end

    // Directed table. An exact hit at index 0 costs zero and no later probe
    // can beat it, so those rows give all-zero results on a fresh turn
    // counter. Unused fields carry junk throughout.
    add_row(load_item(0, 12'hFFF, 12'hFFF, 12'hA5A, 12'h5A5), 1'b0, none);
    add_row(sample_item(12'hFFF, 12'hFFF, 9'h1FF, 12'hFFF, 12'h000), 1'b1, zero_hit);
    add_row(load_item(0, 12'h000, 12'h000, 12'hFFF, 12'hFFF), 1'b0, none);
    add_row(sample_item(12'h000, 12'h000, 9'h155, 12'hAAA, 12'h555), 1'b1, zero_hit);
    add_row(load_item(DEPTH - 1, 12'h000, 12'hFFF, 12'h000, 12'h000), 1'b0, none);
    add_row(sample_item(12'h000, 12'hFFF, 9'h000, 12'h000, 12'hFFF), 1'b0, none);
    add_row(sample_item(12'hFFF, 12'h000, 9'h0AA, 12'h123, 12'hEDC), 1'b0, none);
    // Restore the curve at both ends of the table
    add_row(load_item(0, curve_a(0), curve_b(0), 12'h000, 12'h000), 1'b0, none);
    add_row(load_item(DEPTH - 1, curve_a(DEPTH - 1), curve_b(DEPTH - 1), 12'hFFF, 12'hFFF),
            1'b0, none);
    // Sample at table point 256, half a turn
    add_row(sample_item(curve_a(256), curve_b(256), 9'h0, 12'h0, 12'h0), 1'b0, none);
    // Exactly half a turn back (no turn adjustment), then just past half each way
    add_row(sample_item(curve_a(0), curve_b(0), 9'h1, 12'h1, 12'h1), 1'b0, none);
    add_row(sample_item(curve_a(257), curve_b(257), 9'h2, 12'h2, 12'h2), 1'b0, none);
    add_row(sample_item(curve_a(0), curve_b(0), 9'h3, 12'h3, 12'h3), 1'b0, none);
    // Cross the zero angle both ways
    add_row(sample_item(curve_a(510), curve_b(510), 9'h4, 12'h4, 12'h4), 1'b0, none);
    add_row(sample_item(curve_a(2), curve_b(2), 9'h5, 12'h5, 12'h5), 1'b0, none);
    add_row(sample_item(curve_a(509), curve_b(509), 9'h6, 12'h6, 12'h6), 1'b0, none);
    add_row(sample_item(curve_a(300), curve_b(300), 9'h7, 12'h7, 12'h7), 1'b0, none);
    add_row(sample_item(curve_a(5), curve_b(5), 9'h8, 12'h8, 12'h8), 1'b0, none);

    foreach (directed[i]) begin
      transfer_item(directed[i].stim, directed[i].typed, directed[i].want);
    end

    // Random part in three phases of idle settings
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle  = 13;
          sink_idle = 80;
        end
        1: begin
          src_idle  = 80;
          sink_idle = 13;
        end
        default: begin
          src_idle  = 0;
          sink_idle = 0;
        end
      endcase
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        // Hold off the sender until every pending result has drained
        if (n == PHASE_ITEMS / 3) begin
          s_axis_tvalid <= 1'b0;
          while (pending_results.size() != 0) @(negedge clk_i);
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          // Recalibrate one entry, either on the curve or anywhere
          k = $urandom_range(0, DEPTH - 1);
          if ($urandom_range(0, 1) == 1) begin
            it = load_item(k, FIELD_W'($urandom), FIELD_W'($urandom),
                           FIELD_W'($urandom), FIELD_W'($urandom));
          end else begin
            it = load_item(k, jitter(curve_a(k)), jitter(curve_b(k)),
                           FIELD_W'($urandom), FIELD_W'($urandom));
          end
        end else if (pick < 20) begin
          // Arbitrary reading, possibly far from any table point
          it = sample_item(FIELD_W'($urandom), FIELD_W'($urandom), INDEX_W'($urandom),
                           FIELD_W'($urandom), FIELD_W'($urandom));
        end else if (pick < 40) begin
          // Jump to any shaft position
          walk_pos = $urandom_range(0, DEPTH - 1);
          it = sample_item(jitter(cal_a[walk_pos]), jitter(cal_b[walk_pos]),
                           INDEX_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
        end else begin
          // Rotate a little in either direction
          walk_pos = (walk_pos + DEPTH + $urandom_range(0, 24) - 12) % DEPTH;
          it = sample_item(jitter(cal_a[walk_pos]), jitter(cal_b[walk_pos]),
                           INDEX_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
        end
        transfer_item(it, 1'b0, none);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    // Give a stray late result time to show up
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("** encoder_table_angle_search: PASSED **");
    end else begin
      $display("** encoder_table_angle_search: FAILED **");
    end
    $finish;
  end

endmodule
